FILE: sv/lbce_pkg.sv
// Shared types, codes and helper functions for the line-B compare and EOR unit.
package lbce_pkg;

  localparam logic [1:0] CLS_CMP  = 2'd0;
  localparam logic [1:0] CLS_CMPA = 2'd1;
  localparam logic [1:0] CLS_CMPM = 2'd2;
  localparam logic [1:0] CLS_EOR  = 2'd3;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;
  localparam logic [1:0] SZ_LONG = 2'd2;

  localparam logic [2:0] MODE_AREG = 3'd1;
  localparam logic [2:0] MODE_EXT  = 3'd7;
  localparam logic [2:0] OPM_CMPA_W = 3'd3;
  localparam logic [2:0] OPM_CMPA_L = 3'd7;
  localparam logic [2:0] OPM_EOR_B  = 3'd4;
  localparam logic [2:0] EXT_SRC_MAX = 3'd4;
  localparam logic [2:0] EXT_DST_MAX = 3'd1;

  typedef struct packed {
    logic       illegal;
    logic [1:0] op_class;
    logic [1:0] size_code;
    logic [1:0] alu_size;
  } ctl_t;

  function automatic logic [31:0] size_mask(input logic [1:0] sz);
    case (sz)
      SZ_BYTE: size_mask = 32'h0000_00FF;
      SZ_WORD: size_mask = 32'h0000_FFFF;
      default: size_mask = 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic size_msb(input logic [1:0] sz, input logic [31:0] val);
    case (sz)
      SZ_BYTE: size_msb = val[7];
      SZ_WORD: size_msb = val[15];
      default: size_msb = val[31];
    endcase
  endfunction

endpackage

FILE: sv/lbce_decode.sv
// First stage: opcode decode, legality check and operand sizing.
module lbce_decode
  import lbce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  input  logic        down_en,
  input  logic [11:0] opcode_low,
  input  logic [31:0] ea_value,
  input  logic [31:0] reg_value,
  output logic        en,
  output logic        valid,
  output ctl_t        ctl,
  output logic [31:0] src,
  output logic [31:0] dst
);

  logic [2:0]  opmode;
  logic [2:0]  mode;
  logic [2:0]  rreg;
  logic        src_ok;
  logic        ok;
  ctl_t        ctl_next;
  logic [31:0] src_next;
  logic [31:0] dst_next;
  logic [31:0] mask;

  assign opmode = opcode_low[8:6];
  assign mode   = opcode_low[5:3];
  assign rreg   = opcode_low[2:0];
  assign src_ok = (mode != MODE_EXT) || (rreg <= EXT_SRC_MAX);
  assign en     = !valid || down_en;

  always_comb begin
    ctl_next = '0;
    ok = 1'b0;
    if (opmode <= 3'(SZ_LONG)) begin
      ctl_next.op_class  = CLS_CMP;
      ctl_next.size_code = opmode[1:0];
      ctl_next.alu_size  = opmode[1:0];
      ok = src_ok && !(opmode[1:0] == SZ_BYTE && mode == MODE_AREG);
    end else if (opmode == OPM_CMPA_W || opmode == OPM_CMPA_L) begin
      ctl_next.op_class  = CLS_CMPA;
      ctl_next.size_code = (opmode == OPM_CMPA_W) ? SZ_WORD : SZ_LONG;
      ctl_next.alu_size  = SZ_LONG;
      ok = src_ok;
    end else if (mode == MODE_AREG) begin
      ctl_next.op_class  = CLS_CMPM;
      ctl_next.size_code = 2'(opmode - OPM_EOR_B);
      ctl_next.alu_size  = 2'(opmode - OPM_EOR_B);
      ok = 1'b1;
    end else begin
      ctl_next.op_class  = CLS_EOR;
      ctl_next.size_code = 2'(opmode - OPM_EOR_B);
      ctl_next.alu_size  = 2'(opmode - OPM_EOR_B);
      ok = (mode != MODE_EXT) || (rreg <= EXT_DST_MAX);
    end

    mask = size_mask(ctl_next.alu_size);
    if (ctl_next.op_class == CLS_CMPA && ctl_next.size_code == SZ_WORD) begin
      src_next = {{16{ea_value[15]}}, ea_value[15:0]};
    end else begin
      src_next = ea_value & mask;
    end
    dst_next = reg_value & mask;

    if (!ok) begin
      ctl_next = '0;
      ctl_next.illegal = 1'b1;
      src_next = '0;
      dst_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= up_valid;
    end
    if (en) begin
      ctl <= ctl_next;
      src <= src_next;
      dst <= dst_next;
    end
  end

endmodule

FILE: sv/lbce_alu.sv
// Second stage: subtract or exclusive-or of the sized operands.
module lbce_alu
  import lbce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  input  logic        down_en,
  input  ctl_t        up_ctl,
  input  logic [31:0] src,
  input  logic [31:0] dst,
  output logic        en,
  output logic        valid,
  output ctl_t        ctl,
  output logic [31:0] res,
  output logic        borrow,
  output logic        src_msb,
  output logic        dst_msb
);

  logic [32:0] diff;

  assign en   = !valid || down_en;
  assign diff = {1'b0, dst} - {1'b0, src};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= up_valid;
    end
    if (en) begin
      ctl     <= up_ctl;
      res     <= (up_ctl.op_class == CLS_EOR) ? (dst ^ src) : diff[31:0];
      borrow  <= diff[32];
      src_msb <= size_msb(up_ctl.alu_size, src);
      dst_msb <= size_msb(up_ctl.alu_size, dst);
    end
  end

endmodule

FILE: sv/lbce_flags.sv
// Third stage: condition codes, write-back result and the output register.
module lbce_flags
  import lbce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  input  logic        out_stall,
  input  ctl_t        up_ctl,
  input  logic [31:0] res,
  input  logic        borrow,
  input  logic        src_msb,
  input  logic        dst_msb,
  output logic        en,
  output logic        valid,
  output logic        illegal,
  output logic [1:0]  op_class,
  output logic [1:0]  size_code,
  output logic        flag_n,
  output logic        flag_z,
  output logic        flag_v,
  output logic        flag_c,
  output logic        write_back,
  output logic [31:0] result_value
);

  logic [31:0] sized;
  logic        is_eor;
  logic        res_msb;

  assign en      = !valid || !out_stall;
  assign sized   = res & size_mask(up_ctl.alu_size);
  assign is_eor  = up_ctl.op_class == CLS_EOR;
  assign res_msb = size_msb(up_ctl.alu_size, sized);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= up_valid;
    end
    if (en) begin
      illegal      <= up_ctl.illegal;
      op_class     <= up_ctl.op_class;
      size_code    <= up_ctl.size_code;
      flag_n       <= !up_ctl.illegal && res_msb;
      flag_z       <= !up_ctl.illegal && (sized == 32'd0);
      flag_v       <= !up_ctl.illegal && !is_eor && (dst_msb ^ src_msb) && (dst_msb ^ res_msb);
      flag_c       <= !up_ctl.illegal && !is_eor && borrow;
      write_back   <= !up_ctl.illegal && is_eor;
      result_value <= (!up_ctl.illegal && is_eor) ? sized : 32'd0;
    end
  end

endmodule

FILE: sv/m68k_line_b_compare_eor_unit.sv
// Top level of the line-B compare and EOR execute unit.
//
// The input channel takes one item per cycle while in_stall is low: the low
// 12 opcode bits of a line-B instruction with its fetched effective-address
// and register operands. The output channel gives one item per input item:
// the illegal flag, the operation class and size, the new N, Z, V and C
// flags, and for EOR the write-back request and the sized result.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. The block is a three-stage pipeline of decode, the
// subtract or exclusive-or, and flag generation into the output register.
// An item passes through the decode, ALU and flag registers in that order
// before it shows on the output, and throughput is one item per cycle
// while the output is not stalled.
// Each stage holds its item while the stage after it is full and cannot
// move, so a stall on the output backs up through the stages to in_stall
// without losing or repeating an item. Empty stages keep filling while the
// output is stalled.
// Reset clears all stage valid bits; the pipeline then starts empty.
module m68k_line_b_compare_eor_unit
  import lbce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] opcode_low,
  input  logic [31:0] ea_value,
  input  logic [31:0] reg_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        illegal,
  output logic [1:0]  op_class,
  output logic [1:0]  size_code,
  output logic        flag_n,
  output logic        flag_z,
  output logic        flag_v,
  output logic        flag_c,
  output logic        write_back,
  output logic [31:0] result_value
);

  logic        dec_en;
  logic        dec_valid;
  ctl_t        dec_ctl;
  logic [31:0] dec_src;
  logic [31:0] dec_dst;
  logic        alu_en;
  logic        alu_valid;
  ctl_t        alu_ctl;
  logic [31:0] alu_res;
  logic        alu_borrow;
  logic        alu_src_msb;
  logic        alu_dst_msb;
  logic        flg_en;

  assign in_stall = !dec_en;

  lbce_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (in_valid),
    .down_en    (alu_en),
    .opcode_low (opcode_low),
    .ea_value   (ea_value),
    .reg_value  (reg_value),
    .en         (dec_en),
    .valid      (dec_valid),
    .ctl        (dec_ctl),
    .src        (dec_src),
    .dst        (dec_dst)
  );

  lbce_alu u_alu (
    .clk      (clk),
    .rst      (rst),
    .up_valid (dec_valid),
    .down_en  (flg_en),
    .up_ctl   (dec_ctl),
    .src      (dec_src),
    .dst      (dec_dst),
    .en       (alu_en),
    .valid    (alu_valid),
    .ctl      (alu_ctl),
    .res      (alu_res),
    .borrow   (alu_borrow),
    .src_msb  (alu_src_msb),
    .dst_msb  (alu_dst_msb)
  );

  lbce_flags u_flags (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (alu_valid),
    .out_stall    (out_stall),
    .up_ctl       (alu_ctl),
    .res          (alu_res),
    .borrow       (alu_borrow),
    .src_msb      (alu_src_msb),
    .dst_msb      (alu_dst_msb),
    .en           (flg_en),
    .valid        (out_valid),
    .illegal      (illegal),
    .op_class     (op_class),
    .size_code    (size_code),
    .flag_n       (flag_n),
    .flag_z       (flag_z),
    .flag_v       (flag_v),
    .flag_c       (flag_c),
    .write_back   (write_back),
    .result_value (result_value)
  );

endmodule

FILE: sv/lbce_checker.sv
// Port-level checker for the line-B compare and EOR unit, with its bind.
module lbce_checker
  import lbce_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        illegal,
  input logic [1:0]  op_class,
  input logic [1:0]  size_code,
  input logic        write_back,
  input logic [31:0] result_value
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(illegal))
    else $error("Stalled output item changed.");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("Input stalled while the pipeline output is empty.");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("Accepted item did not reach the output in three cycles.");

  a_illegal_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && illegal |-> op_class == CLS_CMP && size_code == SZ_BYTE &&
      !write_back && result_value == 32'd0)
    else $error("Illegal item carries nonzero fields.");

  a_wb_eor: assert property (@(posedge clk) disable iff (rst)
    out_valid && !illegal && op_class != CLS_EOR |-> !write_back && result_value == 32'd0)
    else $error("Compare item requests write-back.");

endmodule

bind m68k_line_b_compare_eor_unit lbce_checker u_lbce_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .illegal      (illegal),
  .op_class     (op_class),
  .size_code    (size_code),
  .write_back   (write_back),
  .result_value (result_value)
);

FILE: sim/m68k_line_b_compare_eor_unit_test.sv
// Testbench for the line-B compare and EOR execute unit, checked against its own predictor.
`timescale 1ns / 1ps

module m68k_line_b_compare_eor_unit_test
  import lbce_pkg::*;
();

  localparam logic [2:0] MODE_DREG = 3'd0;
  localparam logic [2:0] MODE_IND  = 3'd2;
  localparam logic [2:0] EXT_ABS_W = 3'd0;
  localparam logic [2:0] EXT_ABS_L = 3'd1;
  localparam logic [2:0] EXT_PCREL = 3'd2;
  localparam logic [2:0] EXT_IMM   = 3'd4;
  localparam int MAX_GAP = 14;

  typedef struct packed {
    logic        illegal;
    logic [1:0]  op_class;
    logic [1:0]  size_code;
    logic        n;
    logic        z;
    logic        v;
    logic        c;
    logic        wb;
    logic [31:0] res;
  } lineb_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] opcode_low = '0;
  logic [31:0] ea_value = '0;
  logic [31:0] reg_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        illegal;
  logic [1:0]  op_class;
  logic [1:0]  size_code;
  logic        flag_n;
  logic        flag_z;
  logic        flag_v;
  logic        flag_c;
  logic        write_back;
  logic [31:0] result_value;

  lineb_res_t line_b_results_q[$];
  int         mismatch_cnt = 0;
  int         stall_left = 0;
  bit         gaps_on = 1'b0;
  bit         stalls_on = 1'b0;

  m68k_line_b_compare_eor_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode_low(opcode_low), .ea_value(ea_value), .reg_value(reg_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .illegal(illegal), .op_class(op_class), .size_code(size_code),
    .flag_n(flag_n), .flag_z(flag_z), .flag_v(flag_v), .flag_c(flag_c),
    .write_back(write_back), .result_value(result_value)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [11:0] lineb_op(input logic [2:0] rx, input logic [2:0] opm,
                                           input logic [2:0] mode, input logic [2:0] ry);
    lineb_op = {rx, opm, mode, ry};
  endfunction

  function automatic lineb_res_t compute_line_b(input logic [11:0] op, input logic [31:0] ea,
                                                input logic [31:0] rv);
    lineb_res_t r;
    logic [2:0]  opm;
    logic [2:0]  mode;
    logic [2:0]  rg;
    logic        src_ok;
    logic        ok;
    logic [31:0] m;
    logic [31:0] msb;
    logic [31:0] s;
    logic [31:0] d;
    logic [31:0] dif;
    r = '0;
    opm = op[8:6];
    mode = op[5:3];
    rg = op[2:0];
    src_ok = (mode != MODE_EXT) || (rg <= EXT_SRC_MAX);
    if (opm < OPM_CMPA_W) begin
      r.op_class = CLS_CMP;
      r.size_code = opm[1:0];
      ok = src_ok && !(opm[1:0] == SZ_BYTE && mode == MODE_AREG);
    end else if (opm == OPM_CMPA_W || opm == OPM_CMPA_L) begin
      r.op_class = CLS_CMPA;
      r.size_code = (opm == OPM_CMPA_W) ? SZ_WORD : SZ_LONG;
      ok = src_ok;
    end else if (mode == MODE_AREG) begin
      r.op_class = CLS_CMPM;
      r.size_code = 2'(opm - OPM_EOR_B);
      ok = 1'b1;
    end else begin
      r.op_class = CLS_EOR;
      r.size_code = 2'(opm - OPM_EOR_B);
      ok = (mode != MODE_EXT) || (rg <= EXT_DST_MAX);
    end
    if (!ok) begin
      r = '0;
      r.illegal = 1'b1;
      return r;
    end
    case (r.size_code)
      SZ_BYTE: begin m = 32'h0000_00FF; msb = 32'h0000_0080; end
      SZ_WORD: begin m = 32'h0000_FFFF; msb = 32'h0000_8000; end
      default: begin m = 32'hFFFF_FFFF; msb = 32'h8000_0000; end
    endcase
    if (r.op_class == CLS_EOR) begin
      r.res = (ea ^ rv) & m;
      r.n = |(r.res & msb);
      r.z = (r.res == 32'd0);
      r.wb = 1'b1;
    end else begin
      if (r.op_class == CLS_CMPA) begin
        s = (r.size_code == SZ_WORD) ? {{16{ea[15]}}, ea[15:0]} : ea;
        d = rv;
        m = 32'hFFFF_FFFF;
        msb = 32'h8000_0000;
      end else begin
        s = ea & m;
        d = rv & m;
      end
      dif = (d - s) & m;
      r.n = |(dif & msb);
      r.z = (dif == 32'd0);
      r.v = |((d ^ s) & (d ^ dif) & msb);
      r.c = s > d;
    end
    return r;
  endfunction

  task automatic send_item(input logic [11:0] op, input logic [31:0] ea, input logic [31:0] rv);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode_low <= op;
    ea_value <= ea;
    reg_value <= rv;
    do @(posedge clk); while (in_stall);
    line_b_results_q.push_back(compute_line_b(op, ea, rv));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (line_b_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_out
    lineb_res_t want;
    if (!rst && out_valid && !out_stall) begin
      stall_left = stalls_on ? $urandom_range(0, MAX_GAP) : 0;
      if (line_b_results_q.size() == 0) begin
        check_field("unexpected item", 32'd0, 32'd1);
      end else begin
        want = line_b_results_q.pop_front();
        check_field("illegal", 32'(want.illegal), 32'(illegal));
        check_field("op_class", 32'(want.op_class), 32'(op_class));
        check_field("size_code", 32'(want.size_code), 32'(size_code));
        check_field("flag_n", 32'(want.n), 32'(flag_n));
        check_field("flag_z", 32'(want.z), 32'(flag_z));
        check_field("flag_v", 32'(want.v), 32'(flag_v));
        check_field("flag_c", 32'(want.c), 32'(flag_c));
        check_field("write_back", 32'(want.wb), 32'(write_back));
        check_field("result_value", want.res, result_value);
      end
    end
  end

  task automatic test_compare();
    send_item(lineb_op(3'd0, {1'b0, SZ_BYTE}, MODE_DREG, 3'd1), 32'hFFFF_FF01, 32'h1234_5680);
    send_item(lineb_op(3'd7, {1'b0, SZ_BYTE}, MODE_IND, 3'd3), 32'h0000_00FF, 32'hABCD_EF00);
    send_item(lineb_op(3'd2, {1'b0, SZ_WORD}, MODE_IND, 3'd0), 32'h0001_8000, 32'hFFFF_8000);
    send_item(lineb_op(3'd5, {1'b0, SZ_WORD}, MODE_EXT, EXT_ABS_W), 32'h0000_7FFF, 32'h0000_8000);
    send_item(lineb_op(3'd1, {1'b0, SZ_LONG}, MODE_EXT, EXT_IMM), 32'h0000_0001, 32'h8000_0000);
    send_item(lineb_op(3'd4, {1'b0, SZ_LONG}, MODE_AREG, 3'd6), 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  task automatic test_compare_address();
    send_item(lineb_op(3'd0, OPM_CMPA_W, MODE_DREG, 3'd2), 32'h0000_8000, 32'hFFFF_8000);
    send_item(lineb_op(3'd3, OPM_CMPA_W, MODE_AREG, 3'd5), 32'hFFFF_7FFF, 32'h0000_8000);
    send_item(lineb_op(3'd6, OPM_CMPA_L, MODE_EXT, EXT_IMM), 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(lineb_op(3'd7, OPM_CMPA_L, MODE_EXT, EXT_PCREL), 32'h1234_5678, 32'h1234_5678);
  endtask

  task automatic test_compare_memory();
    send_item(lineb_op(3'd7, OPM_EOR_B, MODE_AREG, 3'd7), 32'h0000_007F, 32'hFFFF_FF80);
    send_item(lineb_op(3'd0, OPM_EOR_B + 3'd1, MODE_AREG, 3'd0), 32'h0000_8000, 32'h0000_8000);
    send_item(lineb_op(3'd4, OPM_EOR_B + 3'd2, MODE_AREG, 3'd2), 32'h7FFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_exclusive_or();
    send_item(lineb_op(3'd1, OPM_EOR_B, MODE_DREG, 3'd0), 32'hFFFF_FF5A, 32'h0000_00A5);
    send_item(lineb_op(3'd2, OPM_EOR_B + 3'd1, MODE_EXT, EXT_ABS_L), 32'hCAFE_1234, 32'h0000_1234);
    send_item(lineb_op(3'd3, OPM_EOR_B + 3'd2, MODE_EXT, EXT_ABS_W), 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(lineb_op(3'd7, OPM_EOR_B + 3'd2, MODE_IND, 3'd7), 32'h0F0F_0F0F, 32'hF0F0_F0F0);
  endtask

  task automatic test_illegal();
    send_item(lineb_op(3'd0, {1'b0, SZ_BYTE}, MODE_AREG, 3'd3), 32'hFFFF_FFFF, 32'h0000_0001);
    send_item(lineb_op(3'd1, {1'b0, SZ_WORD}, MODE_EXT, 3'd5), 32'h0000_0001, 32'hFFFF_FFFF);
    send_item(lineb_op(3'd2, OPM_CMPA_L, MODE_EXT, 3'd7), 32'h8000_0000, 32'h0000_0000);
    send_item(lineb_op(3'd3, OPM_EOR_B, MODE_EXT, EXT_PCREL), 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(lineb_op(3'd4, OPM_EOR_B + 3'd1, MODE_EXT, EXT_IMM), 32'h1234_5678, 32'h8765_4321);
    send_item(12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(12'h000, 32'h0000_0000, 32'h0000_0000);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: pick_operand = 32'h0000_0000;
      1: pick_operand = 32'hFFFF_FFFF;
      2: pick_operand = 32'h8000_0000;
      3: pick_operand = 32'h7FFF_FFFF;
      4: pick_operand = {16'($urandom_range(0, 65535)), 16'h8000};
      5: pick_operand = {16'($urandom_range(0, 65535)), 16'h7F80} | 32'($urandom_range(0, 1));
      default: pick_operand = $urandom;
    endcase
  endfunction

  task automatic test_random(input int count);
    logic [11:0] op;
    logic [31:0] ea;
    logic [31:0] rv;
    for (int i = 0; i < count; i++) begin
      if (i % 128 == 0) begin
        gaps_on = $urandom_range(0, 3) != 0;
        stalls_on = $urandom_range(0, 3) != 0;
      end
      op = 12'($urandom_range(0, 4095));
      if ($urandom_range(0, 3) == 0) op[5:3] = MODE_EXT;
      ea = pick_operand();
      case ($urandom_range(0, 5))
        0: rv = ea;
        1: rv = {16'($urandom), ea[15:0]};
        2: rv = {24'($urandom), ea[7:0]};
        default: rv = pick_operand();
      endcase
      send_item(op, ea, rv);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_compare();
    test_compare_address();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    test_compare_memory();
    test_exclusive_or();
    test_illegal();
    drain_results();
    test_random(850);
    drain_results();
    test_random(850);
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
